/* rtl/mpaf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the marker pose to arena frame block.
// No dependencies.
package mpaf_pkg;

	localparam int ID_W        = 10;
	localparam int POS_W       = 32;
	localparam int PX_W        = 16;
	localparam int SIZE_W      = 16;
	localparam int THETA_W     = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int CNT_W       = 5;

	localparam logic [CFG_IDX_W-1:0] REG_ARENA_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ARENA_HEIGHT = 1'b1;

	localparam logic [SIZE_W-1:0] ARENA_WIDTH_RST  = 16'd1024;
	localparam logic [SIZE_W-1:0] ARENA_HEIGHT_RST = 16'd512;

	// last reference id (origin, x axis, y axis)
	localparam int REF_LAST    = 2;

	localparam int MUL_A_N     = 20;
	localparam int MUL_B_N     = 2;
	localparam int SQRT_N      = 32;
	localparam int SIZE_STEPS  = 16;
	localparam int QUO_N       = 32;
	localparam int CORDIC_N    = 20;

	localparam int ANG_FRAC_SHIFT = 7;
	localparam int ANG_PI_Q20     = 3294199;
	localparam int THETA_LIMIT    = 25736;

	typedef struct packed {
		logic [ID_W-1:0]          marker_id;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
		logic signed [PX_W-1:0]   corner0_x;
		logic signed [PX_W-1:0]   corner0_y;
		logic signed [PX_W-1:0]   corner1_x;
		logic signed [PX_W-1:0]   corner1_y;
	} marker_t;

	typedef struct packed {
		logic [ID_W-1:0]           out_id;
		logic signed [POS_W-1:0]   pose_x;
		logic signed [POS_W-1:0]   pose_y;
		logic signed [THETA_W-1:0] theta;
		logic                      degenerate;
	} pose_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIFF, ST_MULA, ST_CHK, ST_SQRT, ST_MULB, ST_DIVM,
		ST_DIVC, ST_DIVD, ST_CLOAD, ST_NORM, ST_CINIT, ST_CSTEP, ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic mstep;
		logic check;
		logic dstep;
	} div_cmd_t;

	typedef struct packed {
		logic             cap;
		logic             diff;
		logic             mul_en;
		logic             chk;
		logic             sqrt_init;
		logic             sqrt_step;
		div_cmd_t         div;
		logic             cor_load;
		logic             cor_norm;
		logic             cor_init;
		logic             cor_step;
		logic             out_load;
		logic [CNT_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic id_ref;
		logic degen;
		logic cor_zero;
		logic norm_ok;
	} status_t;

	// atan(2^-i) in Q.20
	function automatic logic signed [23:0] atan_q20(input logic [CNT_W-1:0] i);
		logic signed [23:0] r;
		case (i)
			5'd0:  r = 24'sd823550;
			5'd1:  r = 24'sd486170;
			5'd2:  r = 24'sd256879;
			5'd3:  r = 24'sd130396;
			5'd4:  r = 24'sd65451;
			5'd5:  r = 24'sd32757;
			5'd6:  r = 24'sd16383;
			5'd7:  r = 24'sd8192;
			5'd8:  r = 24'sd4096;
			5'd9:  r = 24'sd2048;
			5'd10: r = 24'sd1024;
			5'd11: r = 24'sd512;
			5'd12: r = 24'sd256;
			5'd13: r = 24'sd128;
			5'd14: r = 24'sd64;
			5'd15: r = 24'sd32;
			5'd16: r = 24'sd16;
			5'd17: r = 24'sd8;
			5'd18: r = 24'sd4;
			5'd19: r = 24'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/mpaf_div.sv */
`timescale 1ns / 1ps
// Projection scaler: |dot|*size*512 by shift-add, then rounded restoring divide by 2*den.
// Depends on mpaf_pkg.
module mpaf_div (
	input  logic                    clk,
	input  mpaf_pkg::div_cmd_t      cmd,
	input  logic signed [67:0]      dot,
	input  logic [65:0]             den,
	input  logic [15:0]             size,
	output logic signed [31:0]      res
);

	logic               neg_q;
	logic [91:0]        mcand_q;
	logic [91:0]        rem_q;
	logic [65:0]        den_q;
	logic [15:0]        size_q;
	logic [97:0]        ds_q;
	logic [31:0]        quo_q;
	logic               sat_q;
	logic signed [67:0] mag;
	logic [66:0]        dd;
	logic [31:0]        lim;
	logic [31:0]        val;

	assign mag = dot[67] ? -dot : dot;
	assign dd  = {den_q, 1'b0};
	assign lim = neg_q ? 32'h8000_0000 : 32'h7fff_ffff;
	assign val = (sat_q || quo_q > lim) ? lim : quo_q;
	assign res = neg_q ? -$signed(val) : $signed(val);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q   <= dot[67];
			mcand_q <= {17'b0, mag[65:0], 9'b0};
			rem_q   <= {26'b0, den};
			den_q   <= den;
			size_q  <= size;
		end
		if (cmd.mstep) begin
			if (size_q[0])
				rem_q <= rem_q + mcand_q;
			mcand_q <= {mcand_q[90:0], 1'b0};
			size_q  <= {1'b0, size_q[15:1]};
		end
		if (cmd.check) begin
			sat_q <= {7'b0, rem_q} >= {dd, 32'b0};
			ds_q  <= {dd, 31'b0};
			quo_q <= '0;
		end
		if (cmd.dstep) begin
			if ({6'b0, rem_q} >= ds_q) begin
				rem_q <= rem_q - ds_q[91:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				quo_q <= {quo_q[30:0], 1'b0};
			end
			ds_q <= {1'b0, ds_q[97:1]};
		end
	end

endmodule

/* rtl/mpaf_dp.sv */
`timescale 1ns / 1ps
// Datapath: config and reference registers, shared multiplier with accumulators,
// square roots, two projection scalers and CORDIC. Depends on mpaf_pkg, mpaf_div.
module mpaf_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mpaf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mpaf_pkg::SIZE_W-1:0]         cfg_data,
	input  mpaf_pkg::marker_t                   marker,
	input  mpaf_pkg::cmd_t                      cmd,
	output mpaf_pkg::status_t                   st,
	output mpaf_pkg::pose_t                     pose
);

	localparam logic [3:0] ACC_DX = 4'd0, ACC_DY = 4'd1, ACC_DOTX = 4'd2, ACC_DOTY = 4'd3;
	localparam logic [3:0] ACC_SU = 4'd4, ACC_SV = 4'd5, ACC_PU = 4'd6, ACC_PV = 4'd7;
	localparam logic [3:0] ACC_X  = 4'd8, ACC_Y  = 4'd9;

	logic [15:0]        width_q, height_q;
	logic signed [31:0] rpos_q [3][3];
	logic signed [15:0] rpx_q  [3][2];

	logic [9:0]         id_q;
	logic signed [31:0] pos_q [3];
	logic signed [15:0] c0_q [2];
	logic signed [15:0] c1_q [2];

	logic signed [32:0] om_q [3];
	logic signed [32:0] ax_q [3];
	logic signed [32:0] ay_q [3];
	logic signed [16:0] u_q [2];
	logic signed [16:0] v_q [2];
	logic signed [16:0] dm_q [2];

	logic signed [67:0] acc_q [10];
	logic signed [69:0] prod_s1;
	logic [3:0]         dst_s1;
	logic               mul_v_s1;
	logic signed [34:0] a_op, b_op;
	logic [3:0]         dst;

	logic [63:0]        sn_q [2];
	logic [63:0]        sr_q [2];
	logic [63:0]        sb_q;

	logic signed [31:0] resx, resy;

	logic [63:0]        mx_q, my_q, mmax;
	logic               xneg_q, yneg_q;
	logic signed [31:0] x_q, y_q;
	logic signed [23:0] z_q;
	logic signed [31:0] xs, ys, xi, yi;
	logic signed [67:0] xabs, yabs;
	logic               degen_q;
	logic               id_ref;

	logic [23:0]        zabs, zr;
	logic [16:0]        tm, tc;
	logic signed [15:0] th;

	function automatic logic signed [31:0] shr0(input logic signed [31:0] v,
			input logic [mpaf_pkg::CNT_W-1:0] s);
		logic [31:0] m;
		m = v[31] ? 32'(-v) : v;
		m = m >> s;
		return v[31] ? -$signed(m) : $signed(m);
	endfunction

	assign id_ref = marker.marker_id <= 10'(mpaf_pkg::REF_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mpaf_pkg::ARENA_WIDTH_RST;
			height_q <= mpaf_pkg::ARENA_HEIGHT_RST;
			for (int r = 0; r < 3; r++) begin
				for (int a = 0; a < 3; a++)
					rpos_q[r][a] <= '0;
				for (int a = 0; a < 2; a++)
					rpx_q[r][a] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mpaf_pkg::REG_ARENA_WIDTH:  width_q  <= cfg_data;
					mpaf_pkg::REG_ARENA_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.cap && id_ref) begin
				rpos_q[marker.marker_id[1:0]][0] <= marker.pos_x;
				rpos_q[marker.marker_id[1:0]][1] <= marker.pos_y;
				rpos_q[marker.marker_id[1:0]][2] <= marker.pos_z;
				rpx_q[marker.marker_id[1:0]][0]  <= marker.corner0_x;
				rpx_q[marker.marker_id[1:0]][1]  <= marker.corner0_y;
			end
		end
	end

	// multiplier schedule
	always_comb begin
		a_op = '0;
		b_op = '0;
		dst  = ACC_DX;
		case (cmd.idx)
			5'd0:  begin a_op = 35'(ax_q[0]); b_op = 35'(ax_q[0]); dst = ACC_DX; end
			5'd1:  begin a_op = 35'(ax_q[1]); b_op = 35'(ax_q[1]); dst = ACC_DX; end
			5'd2:  begin a_op = 35'(ax_q[2]); b_op = 35'(ax_q[2]); dst = ACC_DX; end
			5'd3:  begin a_op = 35'(ay_q[0]); b_op = 35'(ay_q[0]); dst = ACC_DY; end
			5'd4:  begin a_op = 35'(ay_q[1]); b_op = 35'(ay_q[1]); dst = ACC_DY; end
			5'd5:  begin a_op = 35'(ay_q[2]); b_op = 35'(ay_q[2]); dst = ACC_DY; end
			5'd6:  begin a_op = 35'(om_q[0]); b_op = 35'(ax_q[0]); dst = ACC_DOTX; end
			5'd7:  begin a_op = 35'(om_q[1]); b_op = 35'(ax_q[1]); dst = ACC_DOTX; end
			5'd8:  begin a_op = 35'(om_q[2]); b_op = 35'(ax_q[2]); dst = ACC_DOTX; end
			5'd9:  begin a_op = 35'(om_q[0]); b_op = 35'(ay_q[0]); dst = ACC_DOTY; end
			5'd10: begin a_op = 35'(om_q[1]); b_op = 35'(ay_q[1]); dst = ACC_DOTY; end
			5'd11: begin a_op = 35'(om_q[2]); b_op = 35'(ay_q[2]); dst = ACC_DOTY; end
			5'd12: begin a_op = 35'(u_q[0]);  b_op = 35'(u_q[0]);  dst = ACC_SU; end
			5'd13: begin a_op = 35'(u_q[1]);  b_op = 35'(u_q[1]);  dst = ACC_SU; end
			5'd14: begin a_op = 35'(v_q[0]);  b_op = 35'(v_q[0]);  dst = ACC_SV; end
			5'd15: begin a_op = 35'(v_q[1]);  b_op = 35'(v_q[1]);  dst = ACC_SV; end
			5'd16: begin a_op = 35'(dm_q[0]); b_op = 35'(u_q[0]);  dst = ACC_PU; end
			5'd17: begin a_op = 35'(dm_q[1]); b_op = 35'(u_q[1]);  dst = ACC_PU; end
			5'd18: begin a_op = 35'(dm_q[0]); b_op = 35'(v_q[0]);  dst = ACC_PV; end
			5'd19: begin a_op = 35'(dm_q[1]); b_op = 35'(v_q[1]);  dst = ACC_PV; end
			5'd20: begin
				a_op = acc_q[ACC_PU][34:0];
				b_op = $signed({4'b0, sr_q[1][30:0]});
				dst  = ACC_X;
			end
			5'd21: begin
				a_op = acc_q[ACC_PV][34:0];
				b_op = $signed({4'b0, sr_q[0][30:0]});
				dst  = ACC_Y;
			end
			default: ;
		endcase
	end

	assign st.id_ref = id_ref;
	assign st.degen  = (acc_q[ACC_DX] == '0) || (acc_q[ACC_DY] == '0) ||
	                   (acc_q[ACC_SU] == '0) || (acc_q[ACC_SV] == '0);

	assign mmax        = (mx_q > my_q) ? mx_q : my_q;
	assign st.cor_zero = (mx_q == '0) && (my_q == '0);
	assign st.norm_ok  = (mmax[63:28] == '0) && mmax[27];

	assign xabs = acc_q[ACC_X][67] ? -acc_q[ACC_X] : acc_q[ACC_X];
	assign yabs = acc_q[ACC_Y][67] ? -acc_q[ACC_Y] : acc_q[ACC_Y];
	assign xi   = xneg_q ? -$signed({4'b0, mx_q[27:0]}) : $signed({4'b0, mx_q[27:0]});
	assign yi   = yneg_q ? -$signed({4'b0, my_q[27:0]}) : $signed({4'b0, my_q[27:0]});
	assign xs   = shr0(x_q, cmd.idx);
	assign ys   = shr0(y_q, cmd.idx);

	// theta: Q.20 to Q3.13, ties away from zero, clamped
	assign zabs = z_q[23] ? 24'(-z_q) : z_q;
	assign zr   = zabs + 24'(1 << (mpaf_pkg::ANG_FRAC_SHIFT - 1));
	assign tm   = zr[23:mpaf_pkg::ANG_FRAC_SHIFT];
	assign tc   = (tm > 17'(mpaf_pkg::THETA_LIMIT)) ? 17'(mpaf_pkg::THETA_LIMIT) : tm;
	assign th   = z_q[23] ? -$signed(tc[15:0]) : $signed(tc[15:0]);

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			id_q     <= marker.marker_id;
			pos_q[0] <= marker.pos_x;
			pos_q[1] <= marker.pos_y;
			pos_q[2] <= marker.pos_z;
			c0_q[0]  <= marker.corner0_x;
			c0_q[1]  <= marker.corner0_y;
			c1_q[0]  <= marker.corner1_x;
			c1_q[1]  <= marker.corner1_y;
		end
		if (cmd.diff) begin
			for (int a = 0; a < 3; a++) begin
				om_q[a] <= 33'(pos_q[a]) - 33'(rpos_q[0][a]);
				ax_q[a] <= 33'(rpos_q[1][a]) - 33'(rpos_q[0][a]);
				ay_q[a] <= 33'(rpos_q[2][a]) - 33'(rpos_q[0][a]);
			end
			for (int a = 0; a < 2; a++) begin
				u_q[a]  <= 17'(rpx_q[1][a]) - 17'(rpx_q[0][a]);
				v_q[a]  <= 17'(rpx_q[2][a]) - 17'(rpx_q[0][a]);
				dm_q[a] <= 17'(c1_q[a]) - 17'(c0_q[a]);
			end
			for (int k = 0; k < 10; k++)
				acc_q[k] <= '0;
		end
		prod_s1  <= a_op * b_op;
		dst_s1   <= dst;
		mul_v_s1 <= cmd.mul_en;
		if (mul_v_s1)
			acc_q[dst_s1] <= acc_q[dst_s1] + 68'(prod_s1);
		if (cmd.chk)
			degen_q <= st.degen;
		if (cmd.sqrt_init) begin
			sn_q[0] <= {4'b0, acc_q[ACC_SU][33:0], 26'b0};
			sn_q[1] <= {4'b0, acc_q[ACC_SV][33:0], 26'b0};
			sr_q[0] <= '0;
			sr_q[1] <= '0;
			sb_q    <= 64'h4000_0000_0000_0000;
		end
		if (cmd.sqrt_step) begin
			for (int k = 0; k < 2; k++) begin
				if (sn_q[k] >= sr_q[k] + sb_q) begin
					sn_q[k] <= sn_q[k] - (sr_q[k] + sb_q);
					sr_q[k] <= (sr_q[k] >> 1) + sb_q;
				end else begin
					sr_q[k] <= sr_q[k] >> 1;
				end
			end
			sb_q <= sb_q >> 2;
		end
		if (cmd.cor_load) begin
			mx_q   <= xabs[63:0];
			my_q   <= yabs[63:0];
			xneg_q <= acc_q[ACC_X][67];
			yneg_q <= acc_q[ACC_Y][67];
		end
		if (cmd.cor_norm) begin
			if (mmax[63:28] != '0) begin
				mx_q <= mx_q >> 1;
				my_q <= my_q >> 1;
			end else begin
				mx_q <= mx_q << 1;
				my_q <= my_q << 1;
			end
		end
		if (cmd.cor_init) begin
			if (xi < 0) begin
				z_q <= (yi >= 0) ? 24'sd3294199 : -24'sd3294199;
				x_q <= -xi;
				y_q <= -yi;
			end else begin
				z_q <= '0;
				x_q <= xi;
				y_q <= yi;
			end
		end
		if (cmd.cor_step) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + mpaf_pkg::atan_q20(cmd.idx);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - mpaf_pkg::atan_q20(cmd.idx);
			end
		end
		if (cmd.out_load) begin
			pose.out_id <= id_q;
			if (degen_q) begin
				pose.pose_x     <= '0;
				pose.pose_y     <= '0;
				pose.theta      <= '0;
				pose.degenerate <= 1'b1;
			end else begin
				pose.pose_x     <= resx;
				pose.pose_y     <= resy;
				pose.theta      <= st.cor_zero ? 16'sd0 : th;
				pose.degenerate <= 1'b0;
			end
		end
	end

	mpaf_div u_div_x (
		.clk  (clk),
		.cmd  (cmd.div),
		.dot  (acc_q[ACC_DOTX]),
		.den  (acc_q[ACC_DX][65:0]),
		.size (width_q),
		.res  (resx)
	);

	mpaf_div u_div_y (
		.clk  (clk),
		.cmd  (cmd.div),
		.dot  (acc_q[ACC_DOTY]),
		.den  (acc_q[ACC_DY][65:0]),
		.size (height_q),
		.res  (resy)
	);

endmodule

/* rtl/mpaf_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer: steps the datapath through products, roots, divides and CORDIC,
// and owns both handshakes. Depends on mpaf_pkg.
module mpaf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                marker_valid,
	output logic                marker_stall,
	output logic                pose_valid,
	input  logic                pose_stall,
	input  mpaf_pkg::status_t   st,
	output mpaf_pkg::cmd_t      cmd
);

	localparam int CNT_W = mpaf_pkg::CNT_W;
	localparam logic [CNT_W-1:0] CNT_W_MULA = CNT_W'(mpaf_pkg::MUL_A_N);

	mpaf_pkg::state_t                 state_q, state_d;
	logic [CNT_W-1:0]                 cnt_q, cnt_d;
	logic                             out_valid_q;

	assign pose_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mpaf_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!pose_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		cmd          = '0;
		marker_stall = 1'b1;
		case (state_q)
			mpaf_pkg::ST_IDLE: begin
				marker_stall = 1'b0;
				if (marker_valid) begin
					cmd.cap = 1'b1;
					if (!st.id_ref)
						state_d = mpaf_pkg::ST_DIFF;
				end
			end
			mpaf_pkg::ST_DIFF: begin
				cmd.diff = 1'b1;
				cnt_d    = '0;
				state_d  = mpaf_pkg::ST_MULA;
			end
			mpaf_pkg::ST_MULA: begin
				cmd.idx    = cnt_q;
				cmd.mul_en = cnt_q != CNT_W_MULA;
				cnt_d      = cnt_q + 1'b1;
				if (cnt_q == CNT_W_MULA)
					state_d = mpaf_pkg::ST_CHK;
			end
			mpaf_pkg::ST_CHK: begin
				cmd.chk = 1'b1;
				cnt_d   = '0;
				if (st.degen) begin
					state_d = mpaf_pkg::ST_FIN;
				end else begin
					cmd.sqrt_init = 1'b1;
					cmd.div.load  = 1'b1;
					state_d       = mpaf_pkg::ST_SQRT;
				end
			end
			mpaf_pkg::ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(mpaf_pkg::SQRT_N - 1)) begin
					cnt_d   = '0;
					state_d = mpaf_pkg::ST_MULB;
				end
			end
			mpaf_pkg::ST_MULB: begin
				cmd.idx    = cnt_q + CNT_W_MULA;
				cmd.mul_en = cnt_q != CNT_W'(mpaf_pkg::MUL_B_N);
				cnt_d      = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(mpaf_pkg::MUL_B_N)) begin
					cnt_d   = '0;
					state_d = mpaf_pkg::ST_DIVM;
				end
			end
			mpaf_pkg::ST_DIVM: begin
				cmd.div.mstep = 1'b1;
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(mpaf_pkg::SIZE_STEPS - 1))
					state_d = mpaf_pkg::ST_DIVC;
			end
			mpaf_pkg::ST_DIVC: begin
				cmd.div.check = 1'b1;
				cnt_d         = '0;
				state_d       = mpaf_pkg::ST_DIVD;
			end
			mpaf_pkg::ST_DIVD: begin
				cmd.div.dstep = 1'b1;
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(mpaf_pkg::QUO_N - 1))
					state_d = mpaf_pkg::ST_CLOAD;
			end
			mpaf_pkg::ST_CLOAD: begin
				cmd.cor_load = 1'b1;
				state_d      = mpaf_pkg::ST_NORM;
			end
			mpaf_pkg::ST_NORM: begin
				if (st.cor_zero)
					state_d = mpaf_pkg::ST_FIN;
				else if (st.norm_ok)
					state_d = mpaf_pkg::ST_CINIT;
				else
					cmd.cor_norm = 1'b1;
			end
			mpaf_pkg::ST_CINIT: begin
				cmd.cor_init = 1'b1;
				cnt_d        = '0;
				state_d      = mpaf_pkg::ST_CSTEP;
			end
			mpaf_pkg::ST_CSTEP: begin
				cmd.cor_step = 1'b1;
				cmd.idx      = cnt_q;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(mpaf_pkg::CORDIC_N - 1))
					state_d = mpaf_pkg::ST_FIN;
			end
			mpaf_pkg::ST_FIN: begin
				if (!out_valid_q || !pose_stall) begin
					cmd.out_load = 1'b1;
					state_d      = mpaf_pkg::ST_IDLE;
				end
			end
			default: state_d = mpaf_pkg::ST_IDLE;
		endcase
	end

endmodule

/* rtl/marker_pose_to_arena_frame.sv */
`timescale 1ns / 1ps
// Top level: marker detections in camera frame to arena pose.
// Depends on mpaf_pkg, mpaf_ctrl, mpaf_dp.
//
//   channel | signals                              | dir | payload
//   marker  | marker_valid, marker_stall, marker   | in  | marker_t
//   pose    | pose_valid, pose_stall, pose         | out | pose_t
//   cfg     | cfg_we, cfg_index, cfg_data          | in  | arena width / height
//
// Reference ids (0..2) are captured and done on acceptance. Tracked markers
// run the 32-step root, 32-step divide and 20-step CORDIC, plus one step per
// normalizing shift of the CORDIC input; a zero axis ends after the check.
// Reset restores arena 4.0 x 2.0 m and clears all references.
// A finished pose waits in the output register; a stalled pose holds the
// block only when the next result is ready.
module marker_pose_to_arena_frame (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            marker_valid,
	output logic                            marker_stall,
	input  mpaf_pkg::marker_t               marker,
	output logic                            pose_valid,
	input  logic                            pose_stall,
	output mpaf_pkg::pose_t                 pose,
	input  logic                            cfg_we,
	input  logic [mpaf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mpaf_pkg::SIZE_W-1:0]     cfg_data
);

	mpaf_pkg::cmd_t    cmd;
	mpaf_pkg::status_t st;

	mpaf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.marker_valid (marker_valid),
		.marker_stall (marker_stall),
		.pose_valid   (pose_valid),
		.pose_stall   (pose_stall),
		.st           (st),
		.cmd          (cmd)
	);

	mpaf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.marker    (marker),
		.cmd       (cmd),
		.st        (st),
		.pose      (pose)
	);

endmodule

/* sim/marker_pose_to_arena_frame_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for marker_pose_to_arena_frame: random and directed markers,
// with its own pose predictor, scoreboard and random idling on both channels.
// Depends on mpaf_pkg and the block's RTL.
module marker_pose_to_arena_frame_test;

	class pose_board;
		mpaf_pkg::pose_t pending_poses[$];
		int        errors;
		int        checked;
		int        tracked;
		int        degen_seen;
		int unsigned width_q8, height_q8;
		longint    org[3], xref[3], yref[3];
		longint    org_px[2], xref_px[2], yref_px[2];
		longint    atan_tab[mpaf_pkg::CORDIC_N];

		function new();
			atan_tab = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
				4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
			width_q8  = 32'(mpaf_pkg::ARENA_WIDTH_RST);
			height_q8 = 32'(mpaf_pkg::ARENA_HEIGHT_RST);
			foreach (org[i]) begin
				org[i] = 0; xref[i] = 0; yref[i] = 0;
			end
			foreach (org_px[i]) begin
				org_px[i] = 0; xref_px[i] = 0; yref_px[i] = 0;
			end
		endfunction

		function void set_size(int unsigned w, int unsigned h);
			width_q8  = w;
			height_q8 = h;
		endfunction

		task report(string what, longint got, longint want);
			errors++;
			$display("MISMATCH %s: got %0d expected %0d", what, got, want);
		endtask

		function logic [127:0] norm2(longint a[3]);
			logic signed [127:0] a0, a1, a2;
			a0 = a[0]; a1 = a[1]; a2 = a[2];
			return a0 * a0 + a1 * a1 + a2 * a2;
		endfunction

		function longint arena_coord(longint om[3], longint ax[3], int unsigned sz,
				logic [127:0] den);
			logic signed [127:0] a0, a1, a2, b0, b1, b2, dot;
			logic [127:0] mag, num, q, lim;
			bit neg;
			a0 = om[0]; a1 = om[1]; a2 = om[2];
			b0 = ax[0]; b1 = ax[1]; b2 = ax[2];
			dot = a0 * b0 + a1 * b1 + a2 * b2;
			neg = dot < 0;
			mag = neg ? -dot : dot;
			num = mag * (128'(sz) << 9) + den;
			q = num / (den << 1);
			lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
			if (q > lim)
				q = lim;
			return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
		endfunction

		function longint unsigned int_sqrt(longint unsigned n);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > n)
				b >>= 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function longint trunc_shift(longint v, int s);
			return v < 0 ? -longint'((-v) >> s) : v >>> s;
		endfunction

		function longint heading(longint yi, longint xi);
			longint unsigned mx, my;
			longint x, y, z, xs, ys, m;
			mx = xi < 0 ? -xi : xi;
			my = yi < 0 ? -yi : yi;
			z = 0;
			if (mx == 0 && my == 0)
				return 0;
			while ((mx > my ? mx : my) >= (64'd1 << 28)) begin
				mx >>= 1; my >>= 1;
			end
			while ((mx > my ? mx : my) < (64'd1 << 27)) begin
				mx <<= 1; my <<= 1;
			end
			x = xi < 0 ? -longint'(mx) : longint'(mx);
			y = yi < 0 ? -longint'(my) : longint'(my);
			if (x < 0) begin
				z = y >= 0 ? mpaf_pkg::ANG_PI_Q20 : -mpaf_pkg::ANG_PI_Q20;
				x = -x;
				y = -y;
			end
			for (int i = 0; i < mpaf_pkg::CORDIC_N; i++) begin
				xs = trunc_shift(x, i);
				ys = trunc_shift(y, i);
				if (y > 0) begin
					x += ys; y -= xs; z += atan_tab[i];
				end else begin
					x -= ys; y += xs; z -= atan_tab[i];
				end
			end
			m = ((z < 0 ? -z : z) + (64'd1 << (mpaf_pkg::ANG_FRAC_SHIFT - 1)))
				>>> mpaf_pkg::ANG_FRAC_SHIFT;
			if (m > mpaf_pkg::THETA_LIMIT)
				m = mpaf_pkg::THETA_LIMIT;
			return z < 0 ? -m : m;
		endfunction

		function void note(mpaf_pkg::marker_t m);
			longint pos[3], ax[3], ay[3], om[3], u[2], v[2], dm[2];
			longint px, py, th, su, sv, nu, nv, pu, pv;
			logic [127:0] dx, dy;
			mpaf_pkg::pose_t p;
			bit degen;
			pos = '{m.pos_x, m.pos_y, m.pos_z};
			if (m.marker_id == 0) begin
				org = pos; org_px = '{m.corner0_x, m.corner0_y};
				return;
			end
			if (m.marker_id == 1) begin
				xref = pos; xref_px = '{m.corner0_x, m.corner0_y};
				return;
			end
			if (m.marker_id == mpaf_pkg::REF_LAST) begin
				yref = pos; yref_px = '{m.corner0_x, m.corner0_y};
				return;
			end
			foreach (ax[i]) begin
				ax[i] = xref[i] - org[i];
				ay[i] = yref[i] - org[i];
				om[i] = pos[i] - org[i];
			end
			foreach (u[i]) begin
				u[i] = xref_px[i] - org_px[i];
				v[i] = yref_px[i] - org_px[i];
			end
			dm[0] = longint'(m.corner1_x) - m.corner0_x;
			dm[1] = longint'(m.corner1_y) - m.corner0_y;
			dx = norm2(ax);
			dy = norm2(ay);
			su = u[0] * u[0] + u[1] * u[1];
			sv = v[0] * v[0] + v[1] * v[1];
			degen = dx == 0 || dy == 0 || su == 0 || sv == 0;
			px = 0; py = 0; th = 0;
			if (!degen) begin
				nu = int_sqrt(su << 26);
				nv = int_sqrt(sv << 26);
				pu = dm[0] * u[0] + dm[1] * u[1];
				pv = dm[0] * v[0] + dm[1] * v[1];
				px = arena_coord(om, ax, width_q8, dx);
				py = arena_coord(om, ay, height_q8, dy);
				th = heading(pv * nu, pu * nv);
			end
			p.out_id     = m.marker_id;
			p.pose_x     = px[31:0];
			p.pose_y     = py[31:0];
			p.theta      = th[15:0];
			p.degenerate = degen;
			pending_poses = {pending_poses, p};
			tracked++;
			if (degen)
				degen_seen++;
		endfunction

		task check(mpaf_pkg::pose_t got);
			mpaf_pkg::pose_t want;
			checked++;
			if (pending_poses.size() == 0) begin
				report("unexpected pose, id", got.out_id, -1);
				return;
			end
			want = pending_poses.pop_front();
			if (got.out_id !== want.out_id)
				report("out_id", got.out_id, want.out_id);
			if (got.pose_x !== want.pose_x)
				report("pose_x", got.pose_x, want.pose_x);
			if (got.pose_y !== want.pose_y)
				report("pose_y", got.pose_y, want.pose_y);
			if (got.theta !== want.theta)
				report("theta", got.theta, want.theta);
			if (got.degenerate !== want.degenerate)
				report("degenerate", got.degenerate, want.degenerate);
		endtask
	endclass

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                marker_valid = 1'b0;
	logic                                marker_stall;
	mpaf_pkg::marker_t                   marker = '0;
	logic                                pose_valid;
	logic                                pose_stall = 1'b0;
	mpaf_pkg::pose_t                     pose;
	logic                                cfg_we = 1'b0;
	logic [mpaf_pkg::CFG_IDX_W-1:0]      cfg_index = mpaf_pkg::REG_ARENA_WIDTH;
	logic [mpaf_pkg::SIZE_W-1:0]         cfg_data = '0;

	pose_board board = new();
	int send_idle, recv_idle;
	int sent_items;
	int quiet_cycles;
	localparam int QUIET_LIMIT = 20000;

	marker_pose_to_arena_frame u_dut (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (pose_valid && !pose_stall)
				board.check(pose);
			if ((pose_valid && !pose_stall) || (marker_valid && !marker_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout with %0d poses pending", board.pending_poses.size());
				$display("marker_pose_to_arena_frame_test: errors");
				$finish;
			end
		end
		pose_stall <= $urandom_range(99) < recv_idle;
	end

	task send(mpaf_pkg::marker_t m);
		while ($urandom_range(99) < send_idle) begin
			marker_valid <= 1'b0;
			@(posedge clk);
		end
		marker       <= m;
		marker_valid <= 1'b1;
		do
			@(posedge clk);
		while (marker_stall);
		board.note(m);
		sent_items++;
	endtask

	task wait_idle();
		marker_valid <= 1'b0;
		while (board.pending_poses.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task set_arena(logic [mpaf_pkg::SIZE_W-1:0] w, logic [mpaf_pkg::SIZE_W-1:0] h);
		cfg_we    <= 1'b1;
		cfg_index <= mpaf_pkg::REG_ARENA_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= mpaf_pkg::REG_ARENA_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_we    <= 1'b0;
		board.set_size(32'(w), 32'(h));
	endtask

	function logic [31:0] rand_pos();
		case ($urandom_range(9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2, 3, 4: return $urandom;
			default: return 32'($signed($urandom_range(2000000))) - 32'sd1000000;
		endcase
	endfunction

	function logic [15:0] rand_px();
		case ($urandom_range(9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2, 3: return 16'($urandom);
			default: return 16'($urandom_range(20000));
		endcase
	endfunction

	function mpaf_pkg::marker_t mk(int id, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [15:0] c0x, logic [15:0] c0y, logic [15:0] c1x, logic [15:0] c1y);
		mpaf_pkg::marker_t m;
		m.marker_id = 10'(id);
		m.pos_x = x; m.pos_y = y; m.pos_z = z;
		m.corner0_x = c0x; m.corner0_y = c0y;
		m.corner1_x = c1x; m.corner1_y = c1y;
		return m;
	endfunction

	function mpaf_pkg::marker_t rand_marker(int id);
		return mk(id, rand_pos(), rand_pos(), rand_pos(),
			rand_px(), rand_px(), rand_px(), rand_px());
	endfunction

	task directed();
		send(mk(3, 0, 0, 0, 0, 0, 16, 0));
		send(mk(0, 0, 0, 0, 0, 0, 0, 0));
		send(mk(1, 32'h10000, 0, 0, 160, 0, 0, 0));
		send(mk(mpaf_pkg::REF_LAST, 0, 32'h10000, 0, 0, 160, 0, 0));
		send(mk(1023, 32'h8000, 32'h8000, 0, 0, 0, 16, 0));
		send(mk(4, 32'h8000, 32'h8000, 0, 5, 5, 5, 5));
		send(mk(5, 0, 0, 0, 0, 0, -16'sd16, 0));
		send(mk(6, 0, 0, 0, 0, 0, -16'sd16, -16'sd1));
		send(mk(7, 0, 0, 0, 0, 0, 0, 16));
		send(mk(8, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 1, 1));
		send(mk(9, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, -16'sd1, 1));
		send(mk(10, 32'h1234, 32'h5678, 0, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff));
		send(mk(1, 0, 0, 0, 0, 0, 0, 0));
		send(mk(11, 32'h8000, 0, 0, 0, 0, 16, 0));
		send(mk(1, 32'h10000, 0, 0, 0, 0, 0, 0));
		send(mk(12, 32'h8000, 0, 0, 0, 0, 16, 0));
		send(mk(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000, 0, 0));
		send(mk(1, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 16'h7fff, 16'h8000, 0, 0));
		send(mk(mpaf_pkg::REF_LAST, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			16'h8000, 16'h7fff, 0, 0));
		send(mk(13, 32'h7fff_ffff, 32'h7fff_ffff, 0, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff));
		send(mk(14, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0));
	endtask

	task random_phase(int count);
		int target, ids[3], n;
		target = sent_items + count;
		while (sent_items < target) begin
			if ($urandom_range(9) < 7) begin
				ids = '{0, 1, mpaf_pkg::REF_LAST};
				ids.shuffle();
				foreach (ids[i])
					send(rand_marker(ids[i]));
				if ($urandom_range(19) == 0)
					send(mk(ids[0], 32'(board.org[0]), 32'(board.org[1]),
						32'(board.org[2]), 16'(board.org_px[0]), 16'(board.org_px[1]),
						0, 0));
				n = $urandom_range(6, 1);
				repeat (n)
					send(rand_marker($urandom_range(9) == 0 ? 1023 : $urandom_range(1023, 3)));
			end else begin
				send(rand_marker($urandom_range(1023)));
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = ph == 0 ? 36 : ph == 1 ? 47 : 0;
			recv_idle = ph == 0 ? 47 : ph == 1 ? 36 : 0;
			if (ph == 1)
				set_arena(16'hffff, 16'h0000);
			else if (ph == 2)
				set_arena(16'h0000, 16'hffff);
			else if (ph == 3)
				set_arena(16'($urandom), 16'($urandom));
			if (ph == 0)
				directed();
			random_phase(330);
			wait_idle();
		end
		$display("covered %0d markers, %0d tracked poses (%0d degenerate), %0d poses checked",
			sent_items, board.tracked, board.degen_seen, board.checked);
		$display("four arena settings incl. zero and full scale, both idling patterns");
		if (board.errors == 0 && board.pending_poses.size() == 0)
			$display("marker_pose_to_arena_frame_test: clean");
		else
			$display("marker_pose_to_arena_frame_test: errors");
		$finish;
	end
endmodule
